// ----- sv/lkd_pkg.sv -----
package lkd_pkg;

	typedef logic [2:0] key_t;
	typedef logic [9:0] sample_t;
	typedef logic [31:0] time_t;
	typedef logic [15:0] debounce_t;

	localparam key_t KEY_NONE = 3'd0;
	localparam key_t KEY_UP   = 3'd1;
	localparam key_t KEY_DOWN = 3'd2;
	localparam key_t KEY_MENU = 3'd3;
	localparam key_t KEY_BACK = 3'd4;

	localparam int NUM_KEYS = 4;

	localparam sample_t UP_LO   = 10'd1000;
	localparam sample_t DOWN_LO = 10'd750;
	localparam sample_t DOWN_HI = 10'd830;
	localparam sample_t MENU_LO = 10'd500;
	localparam sample_t MENU_HI = 10'd600;
	localparam sample_t BACK_LO = 10'd280;
	localparam sample_t BACK_HI = 10'd380;

	localparam debounce_t DEBOUNCE_RST = 16'd50;

endpackage

// ----- sv/lkd_in_if.sv -----
interface lkd_in_if;
	import lkd_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	time_t   time_ms;

	modport source (output valid, output sample, output time_ms, input ready);
	modport sink (input valid, input sample, input time_ms, output ready);

endinterface

// ----- sv/lkd_out_if.sv -----
interface lkd_out_if;
	import lkd_pkg::*;

	logic valid;
	logic ready;
	key_t pressed_key;

	modport source (output valid, output pressed_key, input ready);
	modport sink (input valid, input pressed_key, output ready);

endinterface

// ----- sv/lkd_classify.sv -----
module lkd_classify (
	input  lkd_pkg::sample_t sample,
	output lkd_pkg::key_t    key
);
	import lkd_pkg::*;

	always_comb begin
		priority if (sample > UP_LO) begin
			key = KEY_UP;
		end else if (sample > DOWN_LO && sample < DOWN_HI) begin
			key = KEY_DOWN;
		end else if (sample > MENU_LO && sample < MENU_HI) begin
			key = KEY_MENU;
		end else if (sample > BACK_LO && sample < BACK_HI) begin
			key = KEY_BACK;
		end else begin
			key = KEY_NONE;
		end
	end

endmodule

// ----- sv/ladder_keypad_debounce_unit.sv -----
// Ladder keypad decoder with debounce.
// req: one word per converter reading (sample, time_ms), valid/ready.
// rsp: one word per accepted reading (pressed_key), valid/ready.
// debounce_we/debounce_wdata: write the debounce time in ms; change it
// only while no reading is in flight.
// Pipeline: a reading passes through two register stages, the input register
// and then the result register that holds its result word.
// Throughput: one reading per cycle unless rsp stalls; the key state is
// updated in a single pass between the input register and the result register.
// pressed_key is nonzero once per hold, on the first reading where the same
// key has been stable strictly longer than the debounce time.
// Reset: empty pipeline, no previous key, change time zero, latches clear,
// debounce time 50 ms.
// Stall: a held result keeps rsp.valid up; one more reading may sit in the
// input register, after which req.ready drops until rsp drains.
module ladder_keypad_debounce_unit (
	input  logic               clk,
	input  logic               arst_n,
	lkd_in_if.sink             req,
	lkd_out_if.source          rsp,
	input  logic               debounce_we,
	input  lkd_pkg::debounce_t debounce_wdata
);
	import lkd_pkg::*;

	key_t              cls_in;
	logic              valid_s1;
	key_t              cls_s1;
	time_t             time_s1;
	logic              valid_q;
	key_t              key_q;
	key_t              prev_q;
	time_t             change_q;
	logic [NUM_KEYS-1:0] flags_q;
	debounce_t         debounce_q;

	logic              adv;
	logic              changed;
	time_t             elapsed;
	logic              stable;
	logic [NUM_KEYS-1:0] hit;
	logic [NUM_KEYS-1:0] fire;
	key_t              result;

	lkd_classify u_classify (
		.sample(req.sample),
		.key   (cls_in)
	);

	assign adv       = valid_s1 && (!valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	assign changed = cls_s1 != prev_q;
	assign elapsed = changed ? '0 : time_s1 - change_q;
	assign stable  = elapsed > {16'd0, debounce_q};

	always_comb begin
		result = KEY_NONE;
		for (int k = 0; k < NUM_KEYS; k++) begin
			hit[k]  = stable && (cls_s1 == key_t'(k + 1));
			fire[k] = hit[k] && !flags_q[k];
			if (fire[k]) begin
				result = key_t'(k + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
		end else if (debounce_we) begin
			debounce_q <= debounce_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cls_s1  <= cls_in;
			time_s1 <= req.time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= KEY_NONE;
			change_q <= '0;
			flags_q  <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				prev_q  <= cls_s1;
				flags_q <= hit;
				if (changed) begin
					change_q <= time_s1;
				end
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_q <= result;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.pressed_key = key_q;

	// at most one key can fire per reading
	a_fire_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(fire))
		else $error("more than one key fired");

	// a fired key is latched afterwards
	a_fire_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fire != '0) |=> (flags_q != '0 && key_q != KEY_NONE))
		else $error("fired key not latched");

	// a new key class never reports on its first reading
	a_change_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && changed) |=> (key_q == KEY_NONE))
		else $error("press on class change");

	// results stay in the code range
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (key_q <= KEY_BACK))
		else $error("pressed key out of range");

endmodule

// ----- tb/testbench.sv -----
module testbench;
	import lkd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 325;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		sample_t sample;
		time_t   stamp;
	} reading_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      debounce_we;
	debounce_t debounce_wdata;

	lkd_in_if  req_if ();
	lkd_out_if rsp_if ();

	ladder_keypad_debounce_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_if),
		.rsp            (rsp_if),
		.debounce_we    (debounce_we),
		.debounce_wdata (debounce_wdata)
	);

	reading_t readings_q[$];
	key_t     press_q[$];

	// key tracker state
	key_t      last_key    = KEY_NONE;
	time_t     last_change = '0;
	logic [3:0] latched    = '0;
	debounce_t dbn_set     = DEBOUNCE_RST;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int errors         = 0;
	int cycle_count    = 0;
	time_t clock_ms    = '0;

	logic stall_kick = 1'b0;
	int   stall_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic key_t decode_sample(sample_t s);
		if (s > UP_LO) return KEY_UP;
		if (s > DOWN_LO && s < DOWN_HI) return KEY_DOWN;
		if (s > MENU_LO && s < MENU_HI) return KEY_MENU;
		if (s > BACK_LO && s < BACK_HI) return KEY_BACK;
		return KEY_NONE;
	endfunction

	task automatic predict_press(sample_t s, time_t t);
		key_t  k;
		time_t held;
		logic  steady;
		key_t  hit;
		k = decode_sample(s);
		if (k != last_key) last_change = t;
		held = t - last_change;
		steady = held > {16'd0, dbn_set};
		hit = KEY_NONE;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (k == key_t'(i + 1) && steady) begin
				if (!latched[i]) begin
					hit = key_t'(i + 1);
					latched[i] = 1'b1;
				end
			end else begin
				latched[i] = 1'b0;
			end
		end
		last_key = k;
		press_q.push_back(hit);
	endtask

	function automatic sample_t pick_sample(key_t k);
		case (k)
			KEY_UP:   return sample_t'($urandom_range(1001, 1023));
			KEY_DOWN: return sample_t'($urandom_range(751, 829));
			KEY_MENU: return sample_t'($urandom_range(501, 599));
			KEY_BACK: return sample_t'($urandom_range(281, 379));
			default: begin
				case ($urandom_range(3))
					0: return sample_t'($urandom_range(0, 280));
					1: return sample_t'($urandom_range(380, 500));
					2: return sample_t'($urandom_range(600, 750));
					default: return sample_t'($urandom_range(830, 1000));
				endcase
			end
		endcase
	endfunction

	task automatic add_reading(sample_t s, time_t t);
		reading_t r;
		r.sample = s;
		r.stamp = t;
		readings_q.push_back(r);
	endtask

	task automatic build_phase(int n);
		int count;
		int roll;
		int len;
		int step_max;
		key_t k;
		count = 0;
		step_max = int'(dbn_set) / 3 + 2;
		while (count < n) begin
			roll = $urandom_range(99);
			if (roll < 75) begin
				k = key_t'($urandom_range(1, 4));
				len = $urandom_range(1, 10);
				for (int j = 0; j < len; j++) begin
					clock_ms += time_t'($urandom_range(0, step_max));
					if ($urandom_range(9) == 0)
						add_reading(sample_t'($urandom_range(0, 1023)), clock_ms);
					else
						add_reading(pick_sample(k), clock_ms);
					count++;
				end
			end else if (roll < 90) begin
				len = $urandom_range(1, 4);
				for (int j = 0; j < len; j++) begin
					clock_ms += time_t'($urandom_range(0, step_max));
					add_reading(pick_sample(KEY_NONE), clock_ms);
					count++;
				end
			end else begin
				if ($urandom_range(1) == 0)
					clock_ms = $urandom;
				else
					clock_ms += time_t'($urandom_range(0, step_max));
				add_reading(sample_t'($urandom_range(0, 1023)), clock_ms);
				count++;
			end
		end
	endtask

	task automatic wait_drained();
		while (readings_q.size() != 0 || req_if.valid || press_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_debounce(debounce_t v);
		@(posedge clk);
		debounce_we <= 1'b1;
		debounce_wdata <= v;
		@(posedge clk);
		debounce_we <= 1'b0;
		dbn_set = v;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_if.ready) begin
			if (req_if.valid)
				predict_press(req_if.sample, req_if.time_ms);
			if (readings_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_if.valid <= 1'b1;
				req_if.sample <= readings_q[0].sample;
				req_if.time_ms <= readings_q[0].stamp;
				void'(readings_q.pop_front());
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (stall_kick)
			stall_left <= HOLD_OFF_CYCLES;
		else if (stall_left != 0)
			stall_left <= stall_left - 1;
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (press_q.size() == 0) begin
					$display("%0t: unexpected word, expected none actual %0d",
						$time, rsp_if.pressed_key);
					errors++;
				end else begin
					if (rsp_if.pressed_key !== press_q[0]) begin
						$display("%0t: pressed_key expected %0d actual %0d",
							$time, press_q[0], rsp_if.pressed_key);
						errors++;
					end
					void'(press_q.pop_front());
				end
			end
			rsp_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		debounce_t dbn_list[5];
		arst_n = 1'b0;
		debounce_we = 1'b0;
		debounce_wdata = '0;
		req_if.valid = 1'b0;
		req_if.sample = '0;
		req_if.time_ms = '0;
		rsp_if.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// window edges, press timing, wrap and backwards time
		add_reading(10'd0,    32'd0);
		add_reading(10'd1023, 32'd10);
		add_reading(10'd1023, 32'd60);
		add_reading(10'd1001, 32'd61);
		add_reading(10'd1020, 32'd200);
		add_reading(10'd1000, 32'd210);
		add_reading(10'd751,  32'd220);
		add_reading(10'd829,  32'd300);
		add_reading(10'd830,  32'd310);
		add_reading(10'd750,  32'd320);
		add_reading(10'd501,  32'd330);
		add_reading(10'd599,  32'd400);
		add_reading(10'd600,  32'd410);
		add_reading(10'd500,  32'd420);
		add_reading(10'd281,  32'd430);
		add_reading(10'd379,  32'd481);
		add_reading(10'd380,  32'd490);
		add_reading(10'd280,  32'd500);
		add_reading(10'd1010, 32'hFFFF_FFF0);
		add_reading(10'd1010, 32'h0000_0030);
		add_reading(10'd1010, 32'h0000_0010);
		add_reading(10'd1010, 32'hFFFF_0000);
		add_reading(10'd0,    32'hFFFF_FFFF);
		wait_drained();

		dbn_list[0] = 16'd0;
		dbn_list[1] = 16'hFFFF;
		dbn_list[2] = 16'd1;
		dbn_list[3] = debounce_t'($urandom_range(2, 5000));
		dbn_list[4] = DEBOUNCE_RST;

		for (int p = 0; p < 5; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			set_debounce(dbn_list[p]);
			clock_ms = 32'hFFFF_FFFF - time_t'($urandom_range(0, 200000));
			build_phase(PHASE_ITEMS);
			if (p == 0) begin
				@(posedge clk);
				stall_kick <= 1'b1;
				@(posedge clk);
				stall_kick <= 1'b0;
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (errors == 0 && press_q.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
